/* hdl/segx_pkg.sv */
// ---------------------------------------------------------------------------
// segx_pkg
// Shared types and constants for the 2D segment intersection block.
// ---------------------------------------------------------------------------
package segx_pkg;

	// width of the minimum determinant register
	localparam int CFG_W = 32;

	// status that travels with a quotient pair out of the divider
	typedef struct packed {
		logic ovf_x;	// |num_x| / den does not fit the quotient width
		logic ovf_y;
	} segx_div_flags_t;

endpackage
// ---------------------------------------------------------------------------

/* hdl/segx_in_if.sv */
// ---------------------------------------------------------------------------
// segx_in_if
// Input channel: the two endpoints of segment A and segment B per beat.
// ---------------------------------------------------------------------------
interface segx_in_if #(
	parameter int CW = 16
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_start_x;
	logic signed [CW-1:0] a_start_y;
	logic signed [CW-1:0] a_end_x;
	logic signed [CW-1:0] a_end_y;
	logic signed [CW-1:0] b_start_x;
	logic signed [CW-1:0] b_start_y;
	logic signed [CW-1:0] b_end_x;
	logic signed [CW-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		input  b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface
// ---------------------------------------------------------------------------

/* hdl/segx_out_if.sv */
// ---------------------------------------------------------------------------
// segx_out_if
// Result channel: hit flag and crossing point per beat.
// ---------------------------------------------------------------------------
interface segx_out_if #(
	parameter int OW = 24
);
	logic valid;
	logic ready;
	logic hit;
	logic signed [OW-1:0] cross_x;
	logic signed [OW-1:0] cross_y;

	modport source (
		output valid, hit, cross_x, cross_y,
		input  ready
	);
	modport sink (
		input  valid, hit, cross_x, cross_y,
		output ready
	);
endinterface
// ---------------------------------------------------------------------------

/* hdl/segx_div.sv */
// ---------------------------------------------------------------------------
// segx_div
// Pipelined restoring divider, two numerators over one shared denominator.
// One quotient bit per stage; flags overflow when the quotient needs more
// than QW bits.
// ---------------------------------------------------------------------------
module segx_div import segx_pkg::*; #(
	parameter int NW = 59,
	parameter int DW = 35,
	parameter int QW = 25,
	parameter int SW = 67
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [NW-1:0]         num_x,
	input  logic [NW-1:0]         num_y,
	input  logic [DW-1:0]         den,
	input  logic [SW-1:0]         side_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [QW-1:0]         quo_x,
	output logic [QW-1:0]         quo_y,
	output segx_div_flags_t       flags,
	output logic [SW-1:0]         side_out
);

	localparam int NS = QW + 1;	// init stage plus one stage per quotient bit

	logic                 v_q    [NS];
	logic [DW-1:0]        rx_q   [NS];
	logic [DW-1:0]        ry_q   [NS];
	logic [QW-1:0]        wx_q   [NS];
	logic [QW-1:0]        wy_q   [NS];
	logic [DW-1:0]        den_q  [NS];
	logic [SW-1:0]        side_q [NS];
	segx_div_flags_t      flg_q  [NS];
	logic [NS:0]          rdy;

	// one compare-subtract step: returns {new remainder, quotient bit}
	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
		input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] s;
		t = {r, b};
		s = t - {1'b0, d};
		if (t >= {1'b0, d})
			return {s[DW-1:0], 1'b1};
		else
			return {t[DW-1:0], 1'b0};
	endfunction

	assign rdy[NS]  = out_ready;
	assign in_ready = rdy[0];

	// stage 0: overflow check and remainder seed from the top dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rx_q[0]        <= DW'(num_x[NW-1:QW]);
			ry_q[0]        <= DW'(num_y[NW-1:QW]);
			wx_q[0]        <= num_x[QW-1:0];
			wy_q[0]        <= num_y[QW-1:0];
			den_q[0]       <= den;
			side_q[0]      <= side_in;
			flg_q[0].ovf_x <= DW'(num_x[NW-1:QW]) >= den;
			flg_q[0].ovf_y <= DW'(num_y[NW-1:QW]) >= den;
		end
	end

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_rdy
			assign rdy[k] = !v_q[k] || rdy[k+1];
		end

		for (k = 1; k < NS; k++) begin : g_step
			logic [DW:0] sx;
			logic [DW:0] sy;

			assign sx = div_step(rx_q[k-1], wx_q[k-1][QW-1], den_q[k-1]);
			assign sy = div_step(ry_q[k-1], wy_q[k-1][QW-1], den_q[k-1]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && v_q[k-1]) begin
					rx_q[k]   <= sx[DW:1];
					ry_q[k]   <= sy[DW:1];
					wx_q[k]   <= {wx_q[k-1][QW-2:0], sx[0]};
					wy_q[k]   <= {wy_q[k-1][QW-2:0], sy[0]};
					den_q[k]  <= den_q[k-1];
					side_q[k] <= side_q[k-1];
					flg_q[k]  <= flg_q[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = v_q[NS-1];
	assign quo_x     = wx_q[NS-1];
	assign quo_y     = wy_q[NS-1];
	assign flags     = flg_q[NS-1];
	assign side_out  = side_q[NS-1];

endmodule
// ---------------------------------------------------------------------------

/* hdl/segment_intersection_2d_top.sv */
// ---------------------------------------------------------------------------
// segment_intersection_2d_top
// 2D line segment crossing point in fixed point, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      beat contents
//  segs      in   valid/ready    endpoints of segment A and segment B
//  result    out  valid/ready    hit, cross_x, cross_y
//  cfg       in   cfg_we         min_determinant (write only)
//
//  One beat per cycle while the result side is ready; the divider resolves one
//  quotient bit per stage. Six front stages form the determinant and Cramer
//  numerators, then the divider, then the output register with the bounding
//  box check. Stalls ripple back stage by stage; empty stages keep filling, so
//  input is taken while a result waits. Reset clears all valid bits and sets
//  min_determinant to 1.
// ---------------------------------------------------------------------------
module segment_intersection_2d_top import segx_pkg::*; #(
	parameter int COORD_WIDTH     = 16,
	parameter int EXTRA_FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	segx_in_if.sink          segs,
	segx_out_if.source       result
);

	localparam int CW   = COORD_WIDTH;
	localparam int EF   = EXTRA_FRAC_BITS;
	localparam int DXW  = CW + 1;           // endpoint difference
	localparam int PW   = 2 * DXW;          // product of two differences
	localparam int DETW = PW + 1;           // determinant
	localparam int CPW  = 2 * CW;           // product of two coordinates
	localparam int D1W  = CPW + 1;          // cross terms d1, d2
	localparam int NPW  = D1W + DXW;        // d * dx product
	localparam int NW   = NPW + 1 + EF;     // scaled numerator
	localparam int QW   = CW + EF + 1;      // quotient magnitude bits
	localparam int QSW  = QW + 1;           // signed quotient
	localparam int OW   = CW + EF;          // result coordinate
	localparam int CMPW = DETW > CFG_W ? DETW : CFG_W;
	localparam int SW   = 4 * CW + 3;       // divider sideband

	// config
	logic [CFG_W-1:0] min_det_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= CFG_W'(1);
		end else if (cfg_we) begin
			min_det_q <= cfg_wdata;
		end
	end

	// handshake chain
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_v_q;
	logic div_in_ready, div_out_valid;

	assign rdy_out    = !out_v_q || result.ready;
	assign rdy_s6     = !v_s6 || div_in_ready;
	assign rdy_s5     = !v_s5 || rdy_s6;
	assign rdy_s4     = !v_s4 || rdy_s5;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign segs.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= segs.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// s1: differences, coordinates, per-segment boxes
	logic signed [DXW-1:0] dxa_s1, dya_s1, dxb_s1, dyb_s1;
	logic signed [CW-1:0]  x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [CW-1:0]  alx_s1, ahx_s1, aly_s1, ahy_s1;
	logic signed [CW-1:0]  blx_s1, bhx_s1, bly_s1, bhy_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && segs.valid) begin
			dxa_s1 <= DXW'(segs.a_start_x) - DXW'(segs.a_end_x);
			dya_s1 <= DXW'(segs.a_start_y) - DXW'(segs.a_end_y);
			dxb_s1 <= DXW'(segs.b_start_x) - DXW'(segs.b_end_x);
			dyb_s1 <= DXW'(segs.b_start_y) - DXW'(segs.b_end_y);
			x1_s1  <= segs.a_start_x;
			y1_s1  <= segs.a_start_y;
			x2_s1  <= segs.a_end_x;
			y2_s1  <= segs.a_end_y;
			x3_s1  <= segs.b_start_x;
			y3_s1  <= segs.b_start_y;
			x4_s1  <= segs.b_end_x;
			y4_s1  <= segs.b_end_y;
			alx_s1 <= segs.a_start_x < segs.a_end_x ? segs.a_start_x : segs.a_end_x;
			ahx_s1 <= segs.a_start_x < segs.a_end_x ? segs.a_end_x : segs.a_start_x;
			aly_s1 <= segs.a_start_y < segs.a_end_y ? segs.a_start_y : segs.a_end_y;
			ahy_s1 <= segs.a_start_y < segs.a_end_y ? segs.a_end_y : segs.a_start_y;
			blx_s1 <= segs.b_start_x < segs.b_end_x ? segs.b_start_x : segs.b_end_x;
			bhx_s1 <= segs.b_start_x < segs.b_end_x ? segs.b_end_x : segs.b_start_x;
			bly_s1 <= segs.b_start_y < segs.b_end_y ? segs.b_start_y : segs.b_end_y;
			bhy_s1 <= segs.b_start_y < segs.b_end_y ? segs.b_end_y : segs.b_start_y;
		end
	end

	// s2: products; both boxes merged into their overlap
	logic signed [PW-1:0]  pab_s2, pba_s2;
	logic signed [CPW-1:0] c12_s2, c21_s2, c34_s2, c43_s2;
	logic signed [DXW-1:0] dxa_s2, dya_s2, dxb_s2, dyb_s2;
	logic signed [CW-1:0]  lx_s2, hx_s2, ly_s2, hy_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pab_s2 <= PW'(dxa_s1) * PW'(dyb_s1);
			pba_s2 <= PW'(dya_s1) * PW'(dxb_s1);
			c12_s2 <= CPW'(x1_s1) * CPW'(y2_s1);
			c21_s2 <= CPW'(y1_s1) * CPW'(x2_s1);
			c34_s2 <= CPW'(x3_s1) * CPW'(y4_s1);
			c43_s2 <= CPW'(y3_s1) * CPW'(x4_s1);
			dxa_s2 <= dxa_s1;
			dya_s2 <= dya_s1;
			dxb_s2 <= dxb_s1;
			dyb_s2 <= dyb_s1;
			lx_s2  <= alx_s1 > blx_s1 ? alx_s1 : blx_s1;
			hx_s2  <= ahx_s1 < bhx_s1 ? ahx_s1 : bhx_s1;
			ly_s2  <= aly_s1 > bly_s1 ? aly_s1 : bly_s1;
			hy_s2  <= ahy_s1 < bhy_s1 ? ahy_s1 : bhy_s1;
		end
	end

	// s3: determinant and cross terms
	logic signed [DETW-1:0] det_s3;
	logic signed [D1W-1:0]  d1_s3, d2_s3;
	logic signed [DXW-1:0]  dxa_s3, dya_s3, dxb_s3, dyb_s3;
	logic signed [CW-1:0]   lx_s3, hx_s3, ly_s3, hy_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			det_s3 <= DETW'(pab_s2) - DETW'(pba_s2);
			d1_s3  <= D1W'(c12_s2) - D1W'(c21_s2);
			d2_s3  <= D1W'(c34_s2) - D1W'(c43_s2);
			dxa_s3 <= dxa_s2;
			dya_s3 <= dya_s2;
			dxb_s3 <= dxb_s2;
			dyb_s3 <= dyb_s2;
			lx_s3  <= lx_s2;
			hx_s3  <= hx_s2;
			ly_s3  <= ly_s2;
			hy_s3  <= hy_s2;
		end
	end

	// s4: numerator products, determinant magnitude, parallel test
	logic [DETW-1:0] det_mag;
	assign det_mag = det_s3[DETW-1] ? DETW'(-det_s3) : DETW'(det_s3);

	logic signed [NPW-1:0] m1_s4, m2_s4, m3_s4, m4_s4;
	logic [DETW-1:0]       dmag_s4;
	logic                  dneg_s4, par_s4;
	logic signed [CW-1:0]  lx_s4, hx_s4, ly_s4, hy_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			m1_s4   <= NPW'(d1_s3) * NPW'(dxb_s3);
			m2_s4   <= NPW'(dxa_s3) * NPW'(d2_s3);
			m3_s4   <= NPW'(d1_s3) * NPW'(dyb_s3);
			m4_s4   <= NPW'(dya_s3) * NPW'(d2_s3);
			dmag_s4 <= det_mag;
			dneg_s4 <= det_s3[DETW-1];
			// zero determinant never hits, even with the threshold at zero
			par_s4  <= (det_mag == '0) || (CMPW'(det_mag) < CMPW'(min_det_q));
			lx_s4   <= lx_s3;
			hx_s4   <= hx_s3;
			ly_s4   <= ly_s3;
			hy_s4   <= hy_s3;
		end
	end

	// s5: Cramer numerators with the extra fraction bits
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [DETW-1:0]      dmag_s5;
	logic                 dneg_s5, par_s5;
	logic signed [CW-1:0] lx_s5, hx_s5, ly_s5, hy_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			nx_s5   <= (NW'(m1_s4) - NW'(m2_s4)) <<< EF;
			ny_s5   <= (NW'(m3_s4) - NW'(m4_s4)) <<< EF;
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
			par_s5  <= par_s4;
			lx_s5   <= lx_s4;
			hx_s5   <= hx_s4;
			ly_s5   <= ly_s4;
			hy_s5   <= hy_s4;
		end
	end

	// s6: magnitudes and quotient signs for the divider
	logic [NW-1:0]        nxm_s6, nym_s6;
	logic [DETW-1:0]      dmag_s6;
	logic                 negx_s6, negy_s6, par_s6;
	logic signed [CW-1:0] lx_s6, hx_s6, ly_s6, hy_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			nxm_s6  <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			nym_s6  <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			negx_s6 <= nx_s5[NW-1] ^ dneg_s5;
			negy_s6 <= ny_s5[NW-1] ^ dneg_s5;
			dmag_s6 <= dmag_s5;
			par_s6  <= par_s5;
			lx_s6   <= lx_s5;
			hx_s6   <= hx_s5;
			ly_s6   <= ly_s5;
			hy_s6   <= hy_s5;
		end
	end

	// divider
	logic [SW-1:0]   side_in, side_out;
	logic [QW-1:0]   quo_x, quo_y;
	segx_div_flags_t dflags;

	assign side_in = {negx_s6, negy_s6, par_s6, lx_s6, hx_s6, ly_s6, hy_s6};

	segx_div #(
		.NW (NW),
		.DW (DETW),
		.QW (QW),
		.SW (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_ready  (div_in_ready),
		.num_x     (nxm_s6),
		.num_y     (nym_s6),
		.den       (dmag_s6),
		.side_in   (side_in),
		.out_valid (div_out_valid),
		.out_ready (rdy_out),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.flags     (dflags),
		.side_out  (side_out)
	);

	// output stage: sign the quotients, check the box overlap (scaled)
	logic                  negx_d, negy_d, par_d;
	logic signed [CW-1:0]  lx_d, hx_d, ly_d, hy_d;
	logic signed [QSW-1:0] qx, qy, lxs, hxs, lys, hys;
	logic                  hit_d;

	assign {negx_d, negy_d, par_d, lx_d, hx_d, ly_d, hy_d} = side_out;

	assign qx  = negx_d ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
	assign qy  = negy_d ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
	assign lxs = QSW'(lx_d) <<< EF;
	assign hxs = QSW'(hx_d) <<< EF;
	assign lys = QSW'(ly_d) <<< EF;
	assign hys = QSW'(hy_d) <<< EF;

	assign hit_d = !par_d && !dflags.ovf_x && !dflags.ovf_y
		&& (qx >= lxs) && (qx <= hxs) && (qy >= lys) && (qy <= hys);

	logic                 hit_q;
	logic signed [OW-1:0] cross_x_q, cross_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_out_valid) begin
			hit_q     <= hit_d;
			cross_x_q <= hit_d ? qx[OW-1:0] : '0;
			cross_y_q <= hit_d ? qy[OW-1:0] : '0;
		end
	end

	assign result.valid   = out_v_q;
	assign result.hit     = hit_q;
	assign result.cross_x = cross_x_q;
	assign result.cross_y = cross_y_q;

`ifndef SYNTH
	// a miss always reports the origin
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !hit_q) |-> (cross_x_q == '0 && cross_y_q == '0))
		else $error("miss with nonzero crossing point");

	// a held front stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(dxa_s1) && $stable(dyb_s1)))
		else $error("stage 1 beat lost or changed under stall");

	// a hit never comes from a flagged divide
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(div_out_valid && hit_d) |-> (!dflags.ovf_x && !dflags.ovf_y && !par_d))
		else $error("hit on overflowed or parallel pair");
`endif

endmodule
// ---------------------------------------------------------------------------

/* bench/tb_segment_intersection_2d_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_segment_intersection_2d_top
// Streams segment pairs through the intersection block under random source
// bursts and sink stalls. Every result beat is checked in order against a
// fixed-point Cramer's rule predictor kept in a small scoreboard class.
// ---------------------------------------------------------------------------
module tb_segment_intersection_2d_top import segx_pkg::*;;

	localparam int CW      = 16;
	localparam int EFB     = 8;
	localparam int OW      = CW + EFB;
	localparam int LAT     = CW + EFB + 9;	// pipeline depth of the block
	localparam int DRAIN   = LAT + 10;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic signed [CW-1:0] ax0, ay0, ax1, ay1;
		logic signed [CW-1:0] bx0, by0, bx1, by1;
	} seg_pair_t;

	typedef struct {
		logic                 hit;
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
	} crossing_t;

	// expected crossings, oldest first
	class crossing_board;
		crossing_t   pending_q[$];
		logic [31:0] min_det;
		int          errors;
		int          hits, misses;

		function new();
			min_det = 1;
			errors  = 0;
			hits    = 0;
			misses  = 0;
		endfunction

		// true when v (scaled) lies inside [min(p,r), max(p,r)] scaled
		function bit in_span(longint v, longint p, longint r);
			longint lo, hi;
			lo = (p < r ? p : r) * (64'sd1 <<< EFB);
			hi = (p < r ? r : p) * (64'sd1 <<< EFB);
			return v >= lo && v <= hi;
		endfunction

		function crossing_t solve_crossing(seg_pair_t s);
			crossing_t c;
			longint x1, y1, x2, y2, x3, y3, x4, y4;
			longint dxa, dya, dxb, dyb, det, adet, d1, d2, nx, ny, qx, qy;
			c.hit = 0;
			c.x   = '0;
			c.y   = '0;
			x1 = s.ax0; y1 = s.ay0; x2 = s.ax1; y2 = s.ay1;
			x3 = s.bx0; y3 = s.by0; x4 = s.bx1; y4 = s.by1;
			dxa = x1 - x2; dya = y1 - y2; dxb = x3 - x4; dyb = y3 - y4;
			det = dxa * dyb - dya * dxb;
			adet = det < 0 ? -det : det;
			// parallel (or near enough): no hit, point stays zero
			if (det == 0 || adet < longint'({32'd0, min_det}))
				return c;
			d1 = x1 * y2 - y1 * x2;
			d2 = x3 * y4 - y3 * x4;
			// numerators stay below 2^57, so 64 bits hold them exactly
			nx = (d1 * dxb - dxa * d2) * (64'sd1 <<< EFB);
			ny = (d1 * dyb - dya * d2) * (64'sd1 <<< EFB);
			qx = nx / det;	// truncates toward zero
			qy = ny / det;
			if (in_span(qx, x1, x2) && in_span(qy, y1, y2) &&
			    in_span(qx, x3, x4) && in_span(qy, y3, y4)) begin
				c.hit = 1;
				c.x   = qx[OW-1:0];
				c.y   = qy[OW-1:0];
			end
			return c;
		endfunction

		function void note_pair(seg_pair_t s);
			crossing_t c;
			c = solve_crossing(s);
			if (c.hit) hits++; else misses++;
			pending_q.push_back(c);
		endfunction

		function void check_beat(logic hit, logic signed [OW-1:0] x,
		                         logic signed [OW-1:0] y);
			crossing_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result beat with nothing expected: hit=%0b x=%0d y=%0d",
					         $realtime, hit, x, y);
				return;
			end
			e = pending_q.pop_front();
			if (hit !== e.hit || x !== e.x || y !== e.y) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
					         $realtime, e.hit, e.x, e.y, hit, x, y);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;

	segx_in_if  #(.CW(CW)) segs ();
	segx_out_if #(.OW(OW)) result ();

	segment_intersection_2d_top #(
		.COORD_WIDTH     (CW),
		.EXTRA_FRAC_BITS (EFB)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.segs      (segs),
		.result    (result)
	);

	crossing_board board = new();

	int  hold_req;		// long sink hold-off, picked up by the sink process
	int  burst_left;
	int  beats_in;
	int  cfg_writes;

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog: far beyond the slowest legal run
	initial begin
		#4000000;
		$display("tb_segment_intersection_2d_top: FAIL");
		$finish;
	end

	// monitor: both handshakes sampled at the rising edge, one process
	always @(posedge clk) begin
		if (arst_n) begin
			if (segs.valid && segs.ready) begin
				board.note_pair('{segs.a_start_x, segs.a_start_y, segs.a_end_x,
				                  segs.a_end_y, segs.b_start_x, segs.b_start_y,
				                  segs.b_end_x, segs.b_end_y});
				beats_in++;
			end
			if (result.valid && result.ready)
				board.check_beat(result.hit, result.cross_x, result.cross_y);
		end
	end

	// sink: stall pattern is redrawn at random from four modes; a long hold-off wins
	initial begin : sink_proc
		int cyc, mode, hold_left;
		cyc = 0;
		mode = 0;
		hold_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(3);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				case (mode)
					0: result.ready <= 1'b1;
					1: result.ready <= ($urandom_range(1) == 0);
					2: result.ready <= ($urandom_range(9) != 0);
					default: result.ready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	function automatic logic signed [CW-1:0] rnd_coord(int span);
		return CW'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic seg_pair_t mk_pair(int a, int b, int c, int d,
	                                      int e, int f, int g, int h);
		seg_pair_t s;
		s = '{CW'(a), CW'(b), CW'(c), CW'(d), CW'(e), CW'(f), CW'(g), CW'(h)};
		return s;
	endfunction

	// mostly short crossing-prone segments, some full range, some parallel
	function automatic seg_pair_t rnd_pair();
		seg_pair_t s;
		int kind, px, py, sp;
		kind = $urandom_range(9);
		sp = ($urandom_range(3) == 0) ? 2000 : 64;
		case (kind)
			6, 7: begin
				s = '{CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
				      CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
			end
			8: begin
				// both segments pass through a chosen point
				px = rnd_coord(20000);
				py = rnd_coord(20000);
				s.ax0 = CW'(px - int'(rnd_coord(sp))); s.ay0 = CW'(py - int'(rnd_coord(sp)));
				s.ax1 = CW'(2 * px - int'(s.ax0));      s.ay1 = CW'(2 * py - int'(s.ay0));
				s.bx0 = CW'(px - int'(rnd_coord(sp))); s.by0 = CW'(py - int'(rnd_coord(sp)));
				s.bx1 = CW'(2 * px - int'(s.bx0));      s.by1 = CW'(2 * py - int'(s.by0));
			end
			9: begin
				// B is A shifted: zero determinant
				s.ax0 = rnd_coord(sp); s.ay0 = rnd_coord(sp);
				s.ax1 = rnd_coord(sp); s.ay1 = rnd_coord(sp);
				px = rnd_coord(sp); py = rnd_coord(sp);
				s.bx0 = s.ax0 + CW'(px); s.by0 = s.ay0 + CW'(py);
				s.bx1 = s.ax1 + CW'(px); s.by1 = s.ay1 + CW'(py);
			end
			default: begin
				s = '{rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), rnd_coord(sp),
				      rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), rnd_coord(sp)};
			end
		endcase
		return s;
	endfunction

	// offer one pair; source runs in bursts with random gaps between them
	task automatic send_pair(seg_pair_t s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
			repeat (gap) begin
				@(negedge clk);
				segs.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		segs.valid     <= 1'b1;
		segs.a_start_x <= s.ax0;
		segs.a_start_y <= s.ay0;
		segs.a_end_x   <= s.ax1;
		segs.a_end_y   <= s.ay1;
		segs.b_start_x <= s.bx0;
		segs.b_start_y <= s.by0;
		segs.b_end_x   <= s.bx1;
		segs.b_end_y   <= s.by1;
		do @(posedge clk); while (!segs.ready);
	endtask

	// let the pipe empty; set_min_det then writes min_determinant
	task automatic drain();
		@(negedge clk);
		segs.valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_min_det(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.min_det = v;
		cfg_writes++;
	endtask

	task automatic send_random(int n);
		repeat (n) send_pair(rnd_pair());
	endtask

	initial begin : main_proc
		seg_pair_t directed[$];
		hold_req   = 0;
		burst_left = 0;
		beats_in   = 0;
		cfg_writes = 0;
		arst_n     = 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		segs.valid <= 1'b0;
		segs.a_start_x <= '0; segs.a_start_y <= '0;
		segs.a_end_x   <= '0; segs.a_end_y   <= '0;
		segs.b_start_x <= '0; segs.b_start_y <= '0;
		segs.b_end_x   <= '0; segs.b_end_y   <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: plain X, touching ends, misses, parallel, extremes
		directed.push_back(mk_pair(-10, -10, 10, 10, -10, 10, 10, -10));
		directed.push_back(mk_pair(0, 0, 3, 1, 0, 1, 3, 0));		// fractional point
		directed.push_back(mk_pair(0, 0, 7, 3, 0, 3, 7, 0));
		directed.push_back(mk_pair(0, 0, 10, 0, 10, -5, 10, 5));		// touches A end
		directed.push_back(mk_pair(0, 0, 10, 0, 11, -5, 11, 5));		// just outside A
		directed.push_back(mk_pair(0, 0, 4, 4, 0, 1, 4, 5));		// parallel
		directed.push_back(mk_pair(0, 0, 4, 4, 1, 1, 6, 6));		// collinear
		directed.push_back(mk_pair(0, 0, 0, 0, 1, 2, 3, 4));		// degenerate A
		directed.push_back(mk_pair(-32768, -32768, 32767, 32767,
		                           -32768, 32767, 32767, -32768));
		directed.push_back(mk_pair(32767, 32767, -32768, -32768,
		                           32767, -32768, -32768, 32767));
		directed.push_back(mk_pair(-32768, -32768, -32768, -32768,
		                           -32768, -32768, -32768, -32768));
		directed.push_back(mk_pair(32767, 32767, 32767, 32767,
		                           32767, 32767, 32767, 32767));
		directed.push_back(mk_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
		directed.push_back(mk_pair(-32768, 32767, 32767, -32768, -1, -1, 0, 0));
		directed.push_back(mk_pair(-3, 5, 9, -7, 2, -8, -4, 6));		// negative quotient
		directed.push_back(mk_pair(0, 0, 100, 1, 0, 1, 100, 0));		// small determinant
		directed.push_back(mk_pair(0, 0, 1, 0, 0, 0, 0, 1));		// shared start point
		directed.push_back(mk_pair(-1, 0, 1, 0, 0, -1, 0, 1));
		foreach (directed[i]) send_pair(directed[i]);
		send_random(130);

		// threshold 0: zero determinant must still miss
		set_min_det(32'd0);
		send_pair(mk_pair(0, 0, 4, 4, 1, 1, 6, 6));
		send_pair(mk_pair(0, 0, 4, 4, 0, 1, 4, 5));
		send_pair(mk_pair(0, 0, 1, 0, 0, 0, 0, 1));
		// sink holds off for a long stretch while the source keeps offering
		hold_req = LONG_HOLD;
		send_random(150);

		// largest threshold: only |det| of at least 2^32 - 1 escapes the parallel test
		set_min_det(32'hFFFF_FFFF);
		send_pair(mk_pair(-32768, -32768, 32767, 32767,
		                  -32768, 32767, 32767, -32768));
		send_random(50);

		// mid threshold: small determinants drop out
		set_min_det(32'($urandom_range(1, 1 << 20)));
		send_random(80);
		set_min_det(32'd100);
		send_pair(mk_pair(0, 0, 100, 1, 0, 1, 100, 0));	// |det| is 200, above threshold
		send_random(70);

		set_min_det(32'd1);
		hold_req = LONG_HOLD;
		send_random(100);

		drain();
		$display("Covered %0d segment pairs (%0d hits, %0d misses) over %0d threshold settings",
		         beats_in, board.hits, board.misses, cfg_writes + 1);
		$display("with bursty input, random output stalls and two long output hold-offs.");
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("tb_segment_intersection_2d_top: PASS");
		end else begin
			$display("%0d mismatches, %0d results still expected",
			         board.errors, board.pending_q.size());
			$display("tb_segment_intersection_2d_top: FAIL");
		end
		$finish;
	end

endmodule
// ---------------------------------------------------------------------------
